// File: hdl/i2a_pkg.sv
package i2a_pkg;

    // conversion commands (s_tuser)
    localparam logic [2:0] CMD_CHAR   = 3'd0;
    localparam logic [2:0] CMD_SDEC   = 3'd1;
    localparam logic [2:0] CMD_UDEC   = 3'd2;
    localparam logic [2:0] CMD_HEXL   = 3'd3;
    localparam logic [2:0] CMD_HEXU   = 3'd4;
    localparam logic [2:0] CMD_PTR    = 3'd5;
    localparam logic [2:0] CMD_PCT    = 3'd6;
    localparam logic [2:0] CMD_UNUSED = 3'd7;   // taken, but produces no characters

    localparam int BIN_W      = 32;
    localparam int BCD_DIGITS = 10;
    localparam int BCD_W      = 4 * BCD_DIGITS;
    localparam int WORD_W     = 64;
    localparam int WORD_DIGITS = WORD_W / 4;
    localparam int DCNT_W     = $clog2(WORD_DIGITS + 1);
    localparam int PRE_W      = 40;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PCT   = 8'h25;
    localparam logic [7:0] CH_X     = 8'h78;

    // "(nil)", first character in the low byte
    localparam logic [PRE_W-1:0] NIL_TEXT = {8'h29, 8'h6C, 8'h69, 8'h6E, 8'h28};

    typedef struct packed {
        logic       valid;
        logic       last;
        logic [3:0] digit;
    } dig_status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_PREFIX = 4'b0010,
        ST_CONV   = 4'b0100,
        ST_DIGITS = 4'b1000
    } fsm_t;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        base = upper ? CH_UA : CH_LA;
        if (d < 4'd10)
            digit_char = CH_ZERO + {4'b0, d};
        else
            digit_char = base + {4'b0, d} - 8'd10;
    endfunction

endpackage

// File: hdl/integer_to_ascii_formatter.sv
// Integer to ASCII formatter, printf style.
// Slave channel: one transaction carries a conversion command in s_tuser and
// the 64-bit argument in s_tdata. Master channel: one ASCII character per
// transaction in m_tdata, m_tlast high on the final character of a conversion.
// Unused command 7 produces no characters at all.
// One conversion at a time: s_tready is high only when the previous
// conversion has placed its final character in the output register.
// Order of output, with the receiver always ready:
//   char, percent, "(nil)": the prefix characters, one per cycle.
//   hex / pointer: prefix characters (pointer only), then leading-zero
//     skipping (one nibble a cycle), then one digit per cycle.
//   decimal: the serial binary-to-BCD converter works one bit a cycle, then
//     the ten BCD digits go through leading-zero skipping and output.
// Reset clears the control state and drops any character held for output.
// A stall on the master side simply holds the output register; the
// conversion pauses until the character is taken, nothing is lost.
module integer_to_ascii_formatter
    import i2a_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // value[63:0]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_char[7:0]
    output logic        m_tlast
);

    fsm_t state_reg, state_next;

    logic [PRE_W-1:0] pre_reg;
    logic [2:0]       pre_cnt_reg;
    logic             has_dig_reg;
    logic             bcd_mode_reg;
    logic             upper_reg;
    logic             out_valid_reg;
    logic [7:0]       out_char_reg;
    logic             out_last_reg;

    logic             accept;
    logic             slot_free;
    logic             emit_pre;
    logic             emit_dig;
    logic [31:0]      low32;
    logic [31:0]      mag;
    logic             neg;

    // decoded at acceptance
    logic [PRE_W-1:0]  acc_pre;
    logic [2:0]        acc_pre_cnt;
    logic              acc_dig;
    logic              acc_bcd;
    logic [WORD_W-1:0] hex_word;
    logic [DCNT_W-1:0] hex_cnt;

    logic              bcd_done;
    logic [BCD_W-1:0]  bcd_val;
    logic              conv_load;
    logic              dig_load;
    logic [WORD_W-1:0] dig_word;
    logic [DCNT_W-1:0] dig_cnt;
    dig_status_t       dig;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;

    assign low32 = s_tdata[31:0];
    assign neg   = (s_tuser == CMD_SDEC) && low32[31];
    assign mag   = neg ? (~low32 + 32'd1) : low32;

    always_comb
    begin
        acc_pre     = '0;
        acc_pre_cnt = 3'd0;
        acc_dig     = 1'b0;
        acc_bcd     = 1'b0;
        hex_word    = {low32, 32'b0};
        hex_cnt     = DCNT_W'(8);
        unique case (s_tuser) inside
            CMD_CHAR:
            begin
                acc_pre     = {32'b0, s_tdata[7:0]};
                acc_pre_cnt = 3'd1;
            end
            CMD_SDEC:
            begin
                acc_pre     = {32'b0, CH_MINUS};
                acc_pre_cnt = neg ? 3'd1 : 3'd0;
                acc_dig     = 1'b1;
                acc_bcd     = 1'b1;
            end
            CMD_UDEC:
            begin
                acc_dig = 1'b1;
                acc_bcd = 1'b1;
            end
            CMD_HEXL, CMD_HEXU:
            begin
                acc_dig = 1'b1;
            end
            CMD_PTR:
            begin
                if (s_tdata == 64'd0)
                begin
                    acc_pre     = NIL_TEXT;
                    acc_pre_cnt = 3'd5;
                end
                else
                begin
                    acc_pre     = {24'b0, CH_X, CH_ZERO};
                    acc_pre_cnt = 3'd2;
                    acc_dig     = 1'b1;
                    hex_word    = s_tdata;
                    hex_cnt     = DCNT_W'(WORD_DIGITS);
                end
            end
            CMD_PCT:
            begin
                acc_pre     = {32'b0, CH_PCT};
                acc_pre_cnt = 3'd1;
            end
            default:
            begin
                acc_pre_cnt = 3'd0;
            end
        endcase
    end

    i2a_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (accept && acc_bcd),
        .bin   (mag),
        .done  (bcd_done),
        .bcd   (bcd_val)
    );

    // hex loads straight away, decimal once the BCD word is ready
    assign conv_load = (state_reg == ST_CONV) && bcd_done;
    assign dig_load  = (accept && acc_dig && !acc_bcd) || conv_load;
    assign dig_word  = conv_load ? {bcd_val, {(WORD_W-BCD_W){1'b0}}} : hex_word;
    assign dig_cnt   = conv_load ? DCNT_W'(BCD_DIGITS) : hex_cnt;

    i2a_digits u_digits (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (dig_load),
        .load_word (dig_word),
        .load_cnt  (dig_cnt),
        .advance   (emit_dig),
        .status    (dig)
    );

    assign emit_pre = (state_reg == ST_PREFIX) && slot_free;
    assign emit_dig = (state_reg == ST_DIGITS) && slot_free && dig.valid;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (acc_pre_cnt != 3'd0)
                        state_next = ST_PREFIX;
                    else if (acc_bcd)
                        state_next = ST_CONV;
                    else if (acc_dig)
                        state_next = ST_DIGITS;
                end
            end
            ST_PREFIX:
            begin
                if (emit_pre && pre_cnt_reg == 3'd1)
                begin
                    if (!has_dig_reg)
                        state_next = ST_IDLE;
                    else if (bcd_mode_reg)
                        state_next = ST_CONV;
                    else
                        state_next = ST_DIGITS;
                end
            end
            ST_CONV:
            begin
                if (bcd_done)
                    state_next = ST_DIGITS;
            end
            ST_DIGITS:
            begin
                if (emit_dig && dig.last)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            pre_cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (emit_pre || emit_dig)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            if (accept)
                pre_cnt_reg <= acc_pre_cnt;
            else if (emit_pre)
                pre_cnt_reg <= pre_cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pre_reg      <= acc_pre;
            has_dig_reg  <= acc_dig;
            bcd_mode_reg <= acc_bcd;
            upper_reg    <= (s_tuser == CMD_HEXU);
        end
        else if (emit_pre)
        begin
            pre_reg <= {8'b0, pre_reg[PRE_W-1:8]};
        end

        if (emit_pre)
        begin
            out_char_reg <= pre_reg[7:0];
            out_last_reg <= (pre_cnt_reg == 3'd1) && !has_dig_reg;
        end
        else if (emit_dig)
        begin
            out_char_reg <= digit_char(dig.digit, upper_reg);
            out_last_reg <= dig.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;

endmodule

// File: hdl/i2a_bcd.sv
// Serial binary to BCD (shift and add-3), one bit per cycle.
module i2a_bcd
    import i2a_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [BIN_W-1:0] bin,
    output logic             done,
    output logic [BCD_W-1:0] bcd
);

    localparam int CNT_W = $clog2(BIN_W + 1);

    logic [BIN_W-1:0] bin_reg;
    logic [BCD_W-1:0] bcd_reg;
    logic [BCD_W-1:0] adj;
    logic [CNT_W-1:0] cnt_reg;
    logic             done_reg;

    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= CNT_W'(BIN_W);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
                done_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= bin;
            bcd_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[BIN_W-1]};
            bin_reg <= {bin_reg[BIN_W-2:0], 1'b0};
        end
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

// File: hdl/i2a_digits.sv
// Nibble shifter: drops leading zero digits, then hands out one digit per advance.
module i2a_digits
    import i2a_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  logic [WORD_W-1:0] load_word,
    input  logic [DCNT_W-1:0] load_cnt,
    input  logic              advance,
    output dig_status_t       status
);

    logic [WORD_W-1:0] word_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              started_reg;
    logic [3:0]        top;
    logic              valid;
    logic              shift;

    assign top   = word_reg[WORD_W-1 -: 4];
    assign valid = (cnt_reg != '0) && (started_reg || top != 4'd0 || cnt_reg == DCNT_W'(1));
    // skip a leading zero, or move on once the digit is taken
    assign shift = (cnt_reg != '0) && (advance || !valid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            started_reg <= 1'b0;
        end
        else if (load)
        begin
            cnt_reg     <= load_cnt;
            started_reg <= 1'b0;
        end
        else if (shift)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (advance)
                started_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            word_reg <= load_word;
        else if (shift)
            word_reg <= {word_reg[WORD_W-5:0], 4'b0};
    end

    assign status.valid = valid;
    assign status.last  = (cnt_reg == DCNT_W'(1));
    assign status.digit = top;

endmodule

// File: hdl/i2a_checker.sv
module i2a_checker
    import i2a_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // stalled character stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("m_tvalid dropped under stall");

    // stalled character keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && $stable(m_tlast)))
        else $error("output payload changed under stall");

    // one conversion at a time; the unused command leaves nothing in flight
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tuser != CMD_UNUSED) |=> !s_tready)
        else $error("second transaction taken during a conversion");

    // a conversion mid-way never admits a new command
    a_mid_text: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input ready while text incomplete");

endmodule

bind integer_to_ascii_formatter i2a_checker u_i2a_checker (.*);
